// ===== hdl/fgov_pkg.sv =====
// Shared types, constants and helpers for the EMA frequency governor.
// No dependencies; every other file imports this package.
package fgov_pkg;

    localparam int OBS_W       = 16;
    localparam int FREQ_W      = 14;
    localparam int PCT_W       = 7;
    localparam int SUM_W       = 20;
    localparam int ADJ_W       = 17;
    localparam int DIVD_W      = 28;
    localparam int PROD_W      = 28;
    localparam int CNT_W       = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int OUT_TDATA_W = 32;

    // Reciprocal scaling for the two constant divisions. Each reciprocal is
    // rounded up; its excess times the largest operand stays below 2^shift,
    // so the shifted product equals the truncated quotient.
    localparam int AVG_RCP_W = 20;
    localparam int TGT_RCP_W = 27;
    localparam int AVG_SCL_W = SUM_W + AVG_RCP_W;
    localparam int TGT_SCL_W = PROD_W + TGT_RCP_W;
    localparam int AVG_SHIFT = 23;
    localparam int TGT_SHIFT = 40;

    localparam logic [AVG_RCP_W-1:0] AVG_RECIP = 20'd838861;     // ceil(2^23 / 10)
    localparam logic [TGT_RCP_W-1:0] TGT_RECIP = 27'd109951163;  // ceil(2^40 / 10000)

    localparam logic [OBS_W-1:0]  AVG_SEED     = 16'd5000;
    localparam logic [ADJ_W-1:0]  RAMP_UNITS   = 17'd150;
    localparam logic [ADJ_W-1:0]  WINDOW_ADJ   = 17'd10000;
    localparam logic [PCT_W-1:0]  PCT_FULL     = 7'd100;
    localparam logic [FREQ_W-1:0] MAX_RESET    = 14'd4000;
    localparam logic [FREQ_W-1:0] FLOOR_RESET  = 14'd2600;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_FREQ   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_FREQ = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AVG_SUM,
        S_AVG_STORE,
        S_TGT,
        S_TGT_STORE,
        S_CMP,
        S_PMAX,
        S_PMAX_WAIT,
        S_PMIN,
        S_PMIN_WAIT,
        S_EMIT
    } t_state;

    typedef enum logic [0:0] {
        DIV_PMAX,
        DIV_PMIN
    } t_div_sel;

    typedef struct packed {
        logic     load_obs;
        logic     load_sum;
        logic     load_prod;
        logic     div_start;
        t_div_sel div_sel;
        logic     store_avg;
        logic     store_tgt_max;
        logic     store_tgt;
        logic     store_clamp;
        logic     store_pmax;
        logic     store_pmin;
        logic     load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic tgt_full;
        logic tgt_same;
        logic max_zero;
        logic out_free;
    } t_dp_status;

    // Saturate a quotient to a whole percentage.
    function automatic logic [PCT_W-1:0] sat_pct(input logic [DIVD_W-1:0] q);
        logic [PCT_W-1:0] r;
        if (q > DIVD_W'(PCT_FULL)) begin
            r = PCT_FULL;
        end else begin
            r = q[PCT_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/ema_frequency_governor_unit.sv =====
// Top level of the EMA frequency governor: stream ports, config port.
// Depends on fgov_pkg, fgov_ctrl and fgov_datapath.
//
// Each input item is one tick's observed budget (100 ns units). The block
// folds it into the running average (3*new + 7*old)/10, adds the 150-unit
// ramp latency, scales max_freq_mhz by adjusted/10000 (or takes the maximum
// once the 10000-unit window is reached), and emits a result only when that
// target differs from the last applied frequency; the result is clamped to
// the floor and then to the maximum. One item is worked at a time. The divide
// by 10 and the divide by 10000 are reciprocal multiplies, each split into
// a load step and a store step. The two percentages divide by max_freq_mhz
// on a shared restoring divider that yields one quotient bit per cycle;
// each division holds the sequencer from issue to stored quotient. Once the
// window saturates the divide by 10000 is skipped, a zero maximum skips both
// divisions, and the sequencer waits while the result register stays full.
// The next item is taken as soon as a result sits in the output register,
// which holds it until the downstream side takes it. Write configuration
// only while no item is in flight.
module ema_frequency_governor_unit
    import fgov_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input items
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [OBS_W-1:0]       s_axis_tdata,   // [15:0] observed_budget
    // Result items
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [13:0] applied_freq_mhz, [20:14] max_throttle_pct,
    // [27:21] min_throttle_pct, [31:28] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // Configuration writes: index 0 max_freq_mhz, index 1 floor_freq_mhz
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [FREQ_W-1:0]      i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // Sequence each tick through the scaling steps and divisions.
    fgov_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Hold config, average, last applied value and the result register.
    fgov_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_obs       (s_axis_tdata),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// ===== hdl/fgov_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by both percentage
// divisions. Depends on fgov_pkg.
module fgov_div
    import fgov_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [FREQ_W-1:0] i_divisor,
    output logic              o_busy,
    output logic              o_done,
    output logic [DIVD_W-1:0] o_quotient
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [DIVD_W-1:0] r_quo, n_quo;
    logic [FREQ_W-1:0] r_rem, n_rem;
    logic [FREQ_W-1:0] r_dsr, n_dsr;

    logic [FREQ_W:0]   shifted;
    logic [FREQ_W+1:0] diff;

    assign shifted = {r_rem, r_quo[DIVD_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_dsr};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DIVD_W - 1);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            // Subtract when the shifted remainder covers the divisor.
            if (!diff[FREQ_W+1]) begin
                n_rem = diff[FREQ_W-1:0];
                n_quo = {r_quo[DIVD_W-2:0], 1'b1};
            end else begin
                n_rem = shifted[FREQ_W-1:0];
                n_quo = {r_quo[DIVD_W-2:0], 1'b0};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== hdl/fgov_datapath.sv =====
// Governor datapath: config and state registers, reciprocal scaling, operand
// muxing, clamp, result register. Depends on fgov_pkg and fgov_div.
module fgov_datapath
    import fgov_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_status             o_status,
    input  logic [OBS_W-1:0]       i_obs,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [FREQ_W-1:0]      i_cfg_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [OUT_TDATA_W-1:0] o_out_data
);

    logic [FREQ_W-1:0] r_max, r_floor;
    logic [OBS_W-1:0]  r_avg, r_obs;
    logic [SUM_W-1:0]  r_sum;
    logic [PROD_W-1:0] r_prod;
    logic [FREQ_W-1:0] r_last, r_target, r_applied;
    logic [PCT_W-1:0]  r_pmax, r_pmin;
    logic              r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic [ADJ_W-1:0]     adjusted;
    logic [SUM_W-1:0]     avg_sum;
    logic [AVG_SCL_W-1:0] avg_scaled;
    logic [TGT_SCL_W-1:0] tgt_scaled;
    logic [DIVD_W-1:0]    dividend;
    logic [FREQ_W-1:0]    raised, clamped;
    logic                 div_busy, div_done;
    logic [DIVD_W-1:0]    quotient;
    logic                 max_zero, out_free;
    logic [PCT_W-1:0]     pmax_val, pmin_val;

    assign adjusted = ADJ_W'(r_avg) + RAMP_UNITS;
    assign avg_sum  = SUM_W'(r_obs) * SUM_W'(3) + SUM_W'(r_avg) * SUM_W'(7);
    assign max_zero = (r_max == '0);
    assign out_free = !r_out_valid || i_out_ready;

    // Divide by 10 and by 10000 through rounded-up reciprocals.
    assign avg_scaled = AVG_SCL_W'(r_sum) * AVG_SCL_W'(AVG_RECIP);
    assign tgt_scaled = TGT_SCL_W'(r_prod) * TGT_SCL_W'(TGT_RECIP);

    always_comb begin
        case (i_cmd.div_sel)
            DIV_PMAX: dividend = DIVD_W'(r_applied) * DIVD_W'(PCT_FULL);
            DIV_PMIN: dividend = DIVD_W'(r_floor) * DIVD_W'(PCT_FULL);
            default:  dividend = '0;
        endcase
    end

    // Raise to the floor first, then cap at the maximum so it wins.
    assign raised  = (r_target < r_floor) ? r_floor : r_target;
    assign clamped = (raised > r_max) ? r_max : raised;

    assign pmax_val = max_zero ? '0 : sat_pct(quotient);
    assign pmin_val = max_zero ? ((r_floor == '0) ? '0 : PCT_FULL) : sat_pct(quotient);

    fgov_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (r_max),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max       <= MAX_RESET;
            r_floor     <= FLOOR_RESET;
            r_avg       <= AVG_SEED;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_MAX_FREQ:   r_max   <= i_cfg_data;
                    REG_FLOOR_FREQ: r_floor <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.store_avg) begin
                r_avg <= avg_scaled[AVG_SHIFT +: OBS_W];
            end
            if (i_cmd.store_clamp) begin
                r_last <= clamped;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_obs) begin
            r_obs <= i_obs;
        end
        if (i_cmd.load_sum) begin
            r_sum <= avg_sum;
        end
        // Only taken below the window, so the product fits PROD_W bits.
        if (i_cmd.load_prod) begin
            r_prod <= PROD_W'(r_max) * PROD_W'(adjusted);
        end
        if (i_cmd.store_tgt_max) begin
            r_target <= r_max;
        end else if (i_cmd.store_tgt) begin
            r_target <= tgt_scaled[TGT_SHIFT +: FREQ_W];
        end
        if (i_cmd.store_clamp) begin
            r_applied <= clamped;
        end
        if (i_cmd.store_pmax) begin
            r_pmax <= pmax_val;
        end
        if (i_cmd.store_pmin) begin
            r_pmin <= pmin_val;
        end
        if (i_cmd.load_out) begin
            r_out_data <= OUT_TDATA_W'({r_pmin, r_pmax, r_applied});
        end
    end

    assign o_status.div_busy = div_busy;
    assign o_status.div_done = div_done;
    assign o_status.tgt_full = (adjusted >= WINDOW_ADJ);
    assign o_status.tgt_same = (r_target == r_last);
    assign o_status.max_zero = max_zero;
    assign o_status.out_free = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> out_free)
        else $error("result register overwritten while waiting");

    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> !div_busy)
        else $error("divider done while still busy");

endmodule

// ===== hdl/fgov_ctrl.sv =====
// Governor sequencer: steps one tick through average, target, clamp and
// percentage divisions. Depends on fgov_pkg.
module fgov_ctrl
    import fgov_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (i_in_valid) n_state = S_AVG_SUM;
            S_AVG_SUM:   n_state = S_AVG_STORE;
            S_AVG_STORE: n_state = S_TGT;
            S_TGT:       n_state = i_status.tgt_full ? S_CMP : S_TGT_STORE;
            S_TGT_STORE: n_state = S_CMP;
            S_CMP:       n_state = i_status.tgt_same ? S_IDLE : S_PMAX;
            S_PMAX:      n_state = i_status.max_zero ? S_EMIT : S_PMAX_WAIT;
            S_PMAX_WAIT: if (i_status.div_done) n_state = S_PMIN;
            S_PMIN:      n_state = S_PMIN_WAIT;
            S_PMIN_WAIT: if (i_status.div_done) n_state = S_EMIT;
            S_EMIT:      if (i_status.out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.div_sel = DIV_PMAX;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.load_obs = i_in_valid;
            end
            S_AVG_SUM: begin
                o_cmd.load_sum = 1'b1;
            end
            S_AVG_STORE: begin
                o_cmd.store_avg = 1'b1;
            end
            S_TGT: begin
                o_cmd.store_tgt_max = i_status.tgt_full;
                o_cmd.load_prod     = !i_status.tgt_full;
            end
            S_TGT_STORE: begin
                o_cmd.store_tgt = 1'b1;
            end
            S_CMP: begin
                o_cmd.store_clamp = !i_status.tgt_same;
            end
            S_PMAX: begin
                o_cmd.div_sel    = DIV_PMAX;
                o_cmd.div_start  = !i_status.max_zero;
                o_cmd.store_pmax = i_status.max_zero;
                o_cmd.store_pmin = i_status.max_zero;
            end
            S_PMAX_WAIT: begin
                o_cmd.store_pmax = i_status.div_done;
            end
            S_PMIN: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_PMIN;
            end
            S_PMIN_WAIT: begin
                o_cmd.store_pmin = i_status.div_done;
            end
            S_EMIT: begin
                o_cmd.load_out = i_status.out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
